@@ hw/rtl/pli_pkg.sv @@
`default_nettype none
package pli_pkg;

	localparam int unsigned DW              = 32;
	localparam int unsigned SLOT_W          = 6;
	localparam int unsigned CNT_W           = 7;
	localparam int unsigned SEG_W           = 6;
	localparam int unsigned CODE_W          = 2;
	localparam int unsigned TABLE_DEPTH_DEF = 64;
	localparam int unsigned DIV_CW          = $clog2(DW);

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [CODE_W-1:0] CC_INTERIOR = 2'd0;
	localparam logic [CODE_W-1:0] CC_LOW      = 2'd1;
	localparam logic [CODE_W-1:0] CC_HIGH     = 2'd2;
	localparam logic [CODE_W-1:0] CC_SHORT    = 2'd3;

	localparam logic [2:0] AS_ZERO  = 3'd0;
	localparam logic [2:0] AS_LAST  = 3'd1;
	localparam logic [2:0] AS_LOW   = 3'd2;
	localparam logic [2:0] AS_LOWP1 = 3'd3;
	localparam logic [2:0] AS_MID   = 3'd4;

	localparam logic [2:0] RS_ZERO  = 3'd0;
	localparam logic [2:0] RS_ONE   = 3'd1;
	localparam logic [2:0] RS_LOW   = 3'd2;
	localparam logic [2:0] RS_HIGH  = 3'd3;
	localparam logic [2:0] RS_FLAT  = 3'd4;
	localparam logic [2:0] RS_BLEND = 3'd5;

	typedef struct packed {
		logic       idle;
		logic       capture;
		logic       rd_en;
		logic [2:0] addr_sel;
		logic       hunt_init;
		logic       bis_init;
		logic       low_dec;
		logic       low_inc;
		logic       bis_step;
		logic       seg_commit;
		logic       lat_lo;
		logic       lat_hi;
		logic       prep;
		logic       mul1;
		logic       mul2;
		logic       div_init;
		logic       div_step;
		logic       res_load;
		logic [2:0] res_sel;
	} pli_cmd_t;

	typedef struct packed {
		logic req_valid;
		logic req_query;
		logic n_zero;
		logic n_one;
		logic x_lt_rd;
		logic x_le_rd;
		logic hunt_ok;
		logic low_zero;
		logic low_top;
		logic bis_done;
		logic flat;
		logic div_done;
		logic out_free;
	} pli_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/pli_in_if.sv @@
`default_nettype none
interface pli_in_if;
	import pli_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     cmd;
	logic [SLOT_W-1:0]        point_index;
	logic signed [DW-1:0]     point_x;
	logic signed [DW-1:0]     point_y;
	logic signed [DW-1:0]     query_x;
	logic                     use_hint;

	modport source (output valid, cmd, point_index, point_x, point_y, query_x, use_hint,
		input ready);
	modport sink (input valid, cmd, point_index, point_x, point_y, query_x, use_hint,
		output ready);

endinterface
`default_nettype wire

@@ hw/rtl/pli_out_if.sv @@
`default_nettype none
interface pli_out_if;
	import pli_pkg::*;

	logic                 valid;
	logic                 ready;
	logic signed [DW-1:0] y_value;
	logic [SEG_W-1:0]     segment_index;
	logic [CODE_W-1:0]    clamp_code;

	modport source (output valid, y_value, segment_index, clamp_code, input ready);
	modport sink (input valid, y_value, segment_index, clamp_code, output ready);

endinterface
`default_nettype wire

@@ hw/rtl/piecewise_linear_interpolator_top.sv @@
// Load beat: written to the table in the cycle it is accepted (slots below TABLE_DEPTH only), no result.
// Query beat: clamped or short-table queries give a result without a segment search;
// interior queries find the segment by bisection, or by hunt from the hint, stepping
// down or up one slot per probe, then blend its end points with two multiplies and
// the bit-serial divider (a flat segment skips the blend and returns its lower y).
// One query is in flight at a time; the output register lets the next beat in.
// arst_n clears point_count, the segment hint and the control state; table contents
// are left as they are and read as undefined until loaded.
`default_nettype none
module piecewise_linear_interpolator_top #(
	parameter int unsigned TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	pli_in_if.sink                         req,
	pli_out_if.source                      rsp,
	input  wire logic                      cfg_we,
	input  wire logic [pli_pkg::CNT_W-1:0] cfg_wdata
);
	import pli_pkg::*;

	pli_cmd_t cmd;
	pli_sts_t sts;

	pli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	pli_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

@@ hw/rtl/pli_ram.sv @@
`default_nettype none
module pli_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/pli_ctrl.sv @@
`default_nettype none
module pli_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pli_pkg::pli_sts_t sts,
	output pli_pkg::pli_cmd_t      cmd
);
	import pli_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CHK  = 5'd1;
	localparam logic [4:0] S_P0   = 5'd2;
	localparam logic [4:0] S_PN   = 5'd3;
	localparam logic [4:0] S_HA   = 5'd4;
	localparam logic [4:0] S_HC0  = 5'd5;
	localparam logic [4:0] S_HDA  = 5'd6;
	localparam logic [4:0] S_HDC  = 5'd7;
	localparam logic [4:0] S_HUA  = 5'd8;
	localparam logic [4:0] S_HUC  = 5'd9;
	localparam logic [4:0] S_HUT  = 5'd10;
	localparam logic [4:0] S_BA   = 5'd11;
	localparam logic [4:0] S_BC   = 5'd12;
	localparam logic [4:0] S_SEG  = 5'd13;
	localparam logic [4:0] S_SL   = 5'd14;
	localparam logic [4:0] S_SH   = 5'd15;
	localparam logic [4:0] S_PR   = 5'd16;
	localparam logic [4:0] S_M1   = 5'd17;
	localparam logic [4:0] S_M2   = 5'd18;
	localparam logic [4:0] S_DI   = 5'd19;
	localparam logic [4:0] S_DS   = 5'd20;
	localparam logic [4:0] S_DONE = 5'd21;

	logic [4:0] state_q, state_d;
	logic [2:0] pend_q, pend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pend_q  <= RS_ZERO;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pend_d  = pend_q;
		case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.req_valid && sts.req_query) begin
					cmd.capture = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.n_zero) begin
					pend_d  = RS_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = AS_ZERO;
					state_d      = S_P0;
				end
			end
			S_P0: begin
				if (sts.n_one) begin
					pend_d  = RS_ONE;
					state_d = S_DONE;
				end else if (sts.x_le_rd) begin
					pend_d  = RS_LOW;
					state_d = S_DONE;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = AS_LAST;
					state_d      = S_PN;
				end
			end
			S_PN: begin
				if (!sts.x_lt_rd) begin
					pend_d  = RS_HIGH;
					state_d = S_DONE;
				end else if (sts.hunt_ok) begin
					cmd.hunt_init = 1'b1;
					state_d       = S_HA;
				end else begin
					cmd.bis_init = 1'b1;
					state_d      = S_BA;
				end
			end
			S_HA: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = AS_LOW;
				state_d      = S_HC0;
			end
			S_HC0: begin
				if (sts.x_lt_rd) begin
					if (sts.low_zero) begin
						state_d = S_SEG;
					end else begin
						cmd.low_dec = 1'b1;
						state_d     = S_HDA;
					end
				end else if (sts.low_top) begin
					state_d = S_SEG;
				end else begin
					state_d = S_HUA;
				end
			end
			S_HDA: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = AS_LOW;
				state_d      = S_HDC;
			end
			S_HDC: begin
				if (sts.x_lt_rd && !sts.low_zero) begin
					cmd.low_dec = 1'b1;
					state_d     = S_HDA;
				end else begin
					state_d = S_SEG;
				end
			end
			S_HUA: begin
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = AS_LOWP1;
				state_d      = S_HUC;
			end
			S_HUC: begin
				if (!sts.x_lt_rd) begin
					cmd.low_inc = 1'b1;
					state_d     = S_HUT;
				end else begin
					state_d = S_SEG;
				end
			end
			S_HUT: begin
				state_d = sts.low_top ? S_SEG : S_HUA;
			end
			S_BA: begin
				if (sts.bis_done) begin
					state_d = S_SEG;
				end else begin
					cmd.rd_en    = 1'b1;
					cmd.addr_sel = AS_MID;
					state_d      = S_BC;
				end
			end
			S_BC: begin
				cmd.bis_step = 1'b1;
				state_d      = S_BA;
			end
			S_SEG: begin
				cmd.rd_en      = 1'b1;
				cmd.addr_sel   = AS_LOW;
				cmd.seg_commit = 1'b1;
				state_d        = S_SL;
			end
			S_SL: begin
				cmd.lat_lo   = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.addr_sel = AS_LOWP1;
				state_d      = S_SH;
			end
			S_SH: begin
				cmd.lat_hi = 1'b1;
				state_d    = S_PR;
			end
			S_PR: begin
				if (sts.flat) begin
					pend_d  = RS_FLAT;
					state_d = S_DONE;
				end else begin
					cmd.prep = 1'b1;
					state_d  = S_M1;
				end
			end
			S_M1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_M2;
			end
			S_M2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DI;
			end
			S_DI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DS;
			end
			S_DS: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					pend_d  = RS_BLEND;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.res_sel = pend_q;
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hw/rtl/pli_dp.sv @@
`default_nettype none
module pli_dp #(
	parameter int unsigned TABLE_DEPTH = pli_pkg::TABLE_DEPTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pli_pkg::CNT_W-1:0]   cfg_wdata,
	pli_in_if.sink                           req,
	pli_out_if.source                        rsp,
	input  wire pli_pkg::pli_cmd_t           cmd,
	output pli_pkg::pli_sts_t                sts
);
	import pli_pkg::*;

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
	localparam logic [DW-1:0] SIGN = {1'b1, {(DW-1){1'b0}}};

	logic [CNT_W-1:0]     count_q;
	logic [NW-1:0]        n_q, n_next, n_m2;
	logic signed [DW-1:0] x_q;
	logic                 hint_req_q;
	logic                 hint_valid_q;
	logic [IW-1:0]        last_q;
	logic [IW-1:0]        low_q, high_q, mid, raddr;
	logic signed [DW-1:0] xl_q, yl_q, xh_q, yh_q;
	logic [DW-1:0]        a_q, b_q, d_q;
	logic [2*DW-1:0]      prod1_q, prod2_q, sum;
	logic [DW-1:0]        rem_q, quo_q;
	logic [DIV_CW-1:0]    div_cnt_q;
	logic [DW:0]          trial;
	logic                 trial_ge;
	logic [2*DW-1:0]      ram_rd;
	logic                 ram_we;
	logic signed [DW-1:0] rd_x, rd_y;
	logic signed [DW:0]   xl_e, xh_e, xc_e, x_e;
	logic [DW-1:0]        ul, uh, q_s;
	logic signed [DW-1:0] blend, res_y;
	logic [SEG_W-1:0]     res_seg;
	logic [CODE_W-1:0]    res_code;
	logic                 valid_q;
	logic signed [DW-1:0] y_q;
	logic [SEG_W-1:0]     seg_q;
	logic [CODE_W-1:0]    code_q;

	assign ram_we = cmd.idle && req.valid && (req.cmd == CMD_LOAD)
		&& (32'(req.point_index) < TABLE_DEPTH);

	always_comb begin
		case (cmd.addr_sel)
			AS_ZERO:  raddr = '0;
			AS_LAST:  raddr = IW'(n_q - NW'(1));
			AS_LOW:   raddr = low_q;
			AS_LOWP1: raddr = low_q + IW'(1);
			AS_MID:   raddr = mid;
			default:  raddr = '0;
		endcase
	end

	pli_ram #(
		.WIDTH (2 * DW),
		.DEPTH (TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(req.point_index)),
		.wdata ({req.point_x, req.point_y}),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (ram_rd)
	);

	assign rd_x   = ram_rd[2*DW-1:DW];
	assign rd_y   = ram_rd[DW-1:0];
	assign n_next = (32'(count_q) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(count_q);
	assign n_m2   = n_q - NW'(2);
	assign mid    = IW'(({1'b0, low_q} + {1'b0, high_q}) >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			hint_valid_q <= 1'b0;
			last_q       <= '0;
			valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if (cmd.seg_commit) begin
				last_q       <= low_q;
				hint_valid_q <= 1'b1;
			end
			if (cmd.res_load) begin
				valid_q <= 1'b1;
			end else if (rsp.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign xl_e = {xl_q[DW-1], xl_q};
	assign xh_e = {xh_q[DW-1], xh_q};
	assign x_e  = {x_q[DW-1], x_q};
	assign xc_e = (x_q < xl_q) ? xl_e : ((x_q > xh_q) ? xh_e : x_e);
	assign ul   = yl_q ^ SIGN;
	assign uh   = yh_q ^ SIGN;
	assign sum  = prod1_q + prod2_q;
	assign trial    = {rem_q, quo_q[DW-1]};
	assign trial_ge = trial >= {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q        <= req.query_x;
			hint_req_q <= req.use_hint;
			n_q        <= n_next;
		end
		if (cmd.hunt_init) begin
			low_q <= (NW'(last_q) > n_m2) ? IW'(n_m2) : last_q;
		end else if (cmd.bis_init) begin
			low_q  <= '0;
			high_q <= IW'(n_q - NW'(1));
		end else if (cmd.low_dec) begin
			low_q <= low_q - IW'(1);
		end else if (cmd.low_inc) begin
			low_q <= low_q + IW'(1);
		end else if (cmd.bis_step) begin
			if (x_q < rd_x) begin
				high_q <= mid;
			end else begin
				low_q <= mid;
			end
		end
		if (cmd.lat_lo) begin
			xl_q <= rd_x;
			yl_q <= rd_y;
		end
		if (cmd.lat_hi) begin
			xh_q <= rd_x;
			yh_q <= rd_y;
		end
		if (cmd.prep) begin
			a_q <= DW'(xh_e - xc_e);
			b_q <= DW'(xc_e - xl_e);
			d_q <= DW'(xh_e - xl_e);
		end
		if (cmd.mul1) begin
			prod1_q <= a_q * ul;
		end
		if (cmd.mul2) begin
			prod2_q <= b_q * uh;
		end
		if (cmd.div_init) begin
			rem_q     <= sum[2*DW-1:DW];
			quo_q     <= sum[DW-1:0];
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_ge ? DW'(trial - {1'b0, d_q}) : DW'(trial);
			quo_q     <= {quo_q[DW-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + DIV_CW'(1);
		end
		if (cmd.res_load) begin
			y_q    <= res_y;
			seg_q  <= res_seg;
			code_q <= res_code;
		end
	end

	assign q_s   = quo_q ^ SIGN;
	assign blend = ((rem_q != '0) && !quo_q[DW-1]) ? $signed(q_s + DW'(1)) : $signed(q_s);

	always_comb begin
		res_seg = '0;
		case (cmd.res_sel)
			RS_ZERO: begin
				res_y    = '0;
				res_code = CC_SHORT;
			end
			RS_ONE: begin
				res_y    = rd_y;
				res_code = CC_SHORT;
			end
			RS_LOW: begin
				res_y    = rd_y;
				res_code = CC_LOW;
			end
			RS_HIGH: begin
				res_y    = rd_y;
				res_code = CC_HIGH;
			end
			RS_FLAT: begin
				res_y    = yl_q;
				res_seg  = SEG_W'(low_q);
				res_code = CC_INTERIOR;
			end
			RS_BLEND: begin
				res_y    = blend;
				res_seg  = SEG_W'(low_q);
				res_code = CC_INTERIOR;
			end
			default: begin
				res_y    = '0;
				res_code = CC_SHORT;
			end
		endcase
	end

	assign req.ready         = cmd.idle;
	assign rsp.valid         = valid_q;
	assign rsp.y_value       = y_q;
	assign rsp.segment_index = seg_q;
	assign rsp.clamp_code    = code_q;

	assign sts.req_valid = req.valid;
	assign sts.req_query = req.cmd == CMD_QUERY;
	assign sts.n_zero    = n_q == '0;
	assign sts.n_one     = n_q == NW'(1);
	assign sts.x_lt_rd   = x_q < rd_x;
	assign sts.x_le_rd   = x_q <= rd_x;
	assign sts.hunt_ok   = hint_req_q && hint_valid_q && (NW'(last_q) < n_q);
	assign sts.low_zero  = low_q == '0;
	assign sts.low_top   = NW'(low_q) == n_m2;
	assign sts.bis_done  = (high_q - low_q) <= IW'(1);
	assign sts.flat      = xh_q <= xl_q;
	assign sts.div_done  = div_cnt_q == DIV_CW'(DW - 1);
	assign sts.out_free  = !valid_q || rsp.ready;

`ifndef SYNTHESIS
	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> (rem_q < d_q))
		else $error("divider remainder not below divisor");

	a_seg_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_commit |-> ((NW + 1)'(low_q) + (NW + 1)'(2) <= (NW + 1)'(n_q)))
		else $error("segment beyond table end");

	a_res_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!valid_q || rsp.ready))
		else $error("result register overwritten");

	a_bis_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.bis_step |-> (low_q < mid && mid < high_q))
		else $error("bisection probe outside bracket");
`endif

endmodule
`default_nettype wire

@@ tb/sv/piecewise_linear_interpolator_top_tb.sv @@
`default_nettype none
module piecewise_linear_interpolator_top_tb;
	import pli_pkg::*;

	typedef struct {
		logic signed [DW-1:0] y;
		logic [SEG_W-1:0]     seg;
		logic [CODE_W-1:0]    code;
	} interp_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	pli_in_if  req_if ();
	pli_out_if rsp_if ();

	piecewise_linear_interpolator_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if.sink),
		.rsp       (rsp_if.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	logic signed [DW-1:0] bp_x [0:TABLE_DEPTH_DEF-1];
	logic signed [DW-1:0] bp_y [0:TABLE_DEPTH_DEF-1];
	int unsigned          seg_memo;
	bit                   seg_memo_ok;
	int unsigned          pts_in_use;

	interp_res_t pending_y [$];
	int          err_cnt;
	int          beats_sent;
	int          gap_pct;
	int          stall_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 3000000);
		$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(negedge clk) begin
		interp_res_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (pending_y.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected beat y=%h seg=%0d code=%0d", $time,
					rsp_if.y_value, rsp_if.segment_index, rsp_if.clamp_code);
			end else begin
				e = pending_y.pop_front();
				if (e.y !== rsp_if.y_value) begin
					err_cnt++;
					$display("%0t: y_value exp %h got %h", $time, e.y, rsp_if.y_value);
				end
				if (e.seg !== rsp_if.segment_index) begin
					err_cnt++;
					$display("%0t: segment_index exp %0d got %0d", $time, e.seg,
						rsp_if.segment_index);
				end
				if (e.code !== rsp_if.clamp_code) begin
					err_cnt++;
					$display("%0t: clamp_code exp %0d got %0d", $time, e.code,
						rsp_if.clamp_code);
				end
			end
		end
	end

	function automatic int unsigned locate_segment(int unsigned n,
			logic signed [DW-1:0] x, bit hunt);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		if (hunt) begin
			lo = seg_memo;
			if (lo > n - 2)
				lo = n - 2;
			if (x < bp_x[lo]) begin
				while (lo > 0 && x < bp_x[lo])
					lo--;
			end else begin
				while (lo < n - 2 && x >= bp_x[lo + 1])
					lo++;
			end
		end else begin
			hi = n - 1;
			while (hi - lo > 1) begin
				mid = (hi + lo) >> 1;
				if (x < bp_x[mid])
					hi = mid;
				else
					lo = mid;
			end
		end
		return lo;
	endfunction

	function automatic interp_res_t interpolate(logic signed [DW-1:0] x, bit want_hint);
		interp_res_t r;
		int unsigned n;
		int unsigned s;
		longint xl;
		longint xh;
		longint xc;
		logic signed [95:0] num;
		logic signed [95:0] den;
		logic signed [95:0] quo;
		n = (pts_in_use > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : pts_in_use;
		r.y = '0;
		r.seg = '0;
		if (n == 0) begin
			r.code = CC_SHORT;
		end else if (n == 1) begin
			r.y = bp_y[0];
			r.code = CC_SHORT;
		end else if (x <= bp_x[0]) begin
			r.y = bp_y[0];
			r.code = CC_LOW;
		end else if (x >= bp_x[n - 1]) begin
			r.y = bp_y[n - 1];
			r.code = CC_HIGH;
		end else begin
			s = locate_segment(n, x, want_hint && seg_memo_ok && seg_memo < n);
			seg_memo = s;
			seg_memo_ok = 1'b1;
			r.seg = s[SEG_W-1:0];
			r.code = CC_INTERIOR;
			xl = bp_x[s];
			xh = bp_x[s + 1];
			if (xh <= xl) begin
				r.y = bp_y[s];
			end else begin
				xc = x;
				if (xc < xl)
					xc = xl;
				if (xc > xh)
					xc = xh;
				num = 96'(signed'(xh - xc)) * 96'(signed'(bp_y[s]))
					+ 96'(signed'(xc - xl)) * 96'(signed'(bp_y[s + 1]));
				den = 96'(signed'(xh - xl));
				quo = num / den;
				r.y = quo[DW-1:0];
			end
		end
		return r;
	endfunction

	task automatic send_beat(logic cmd, logic [SLOT_W-1:0] slot, logic signed [DW-1:0] px,
			logic signed [DW-1:0] py, logic signed [DW-1:0] qx, logic hint);
		bit done;
		int gap;
		done = 0;
		req_if.valid       <= 1'b1;
		req_if.cmd         <= cmd;
		req_if.point_index <= slot;
		req_if.point_x     <= px;
		req_if.point_y     <= py;
		req_if.query_x     <= qx;
		req_if.use_hint    <= hint;
		while (!done) begin
			@(negedge clk);
			done = req_if.ready;
			@(posedge clk);
		end
		beats_sent++;
		if (cmd == CMD_LOAD) begin
			bp_x[slot] = px;
			bp_y[slot] = py;
		end else begin
			pending_y.push_back(interpolate(qx, hint));
		end
		if ($urandom_range(99) < gap_pct) begin
			req_if.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic load_pt(int slot, logic signed [DW-1:0] px, logic signed [DW-1:0] py);
		send_beat(CMD_LOAD, slot[SLOT_W-1:0], px, py, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic query(logic signed [DW-1:0] qx, logic hint);
		send_beat(CMD_QUERY, SLOT_W'($urandom), $urandom, $urandom, qx, hint);
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		while (pending_y.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_count(int unsigned v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v[CNT_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		pts_in_use = v;
	endtask

	task automatic fill_table(int unsigned n, int unsigned shape);
		int xs [$];
		int base;
		base = $urandom;
		for (int i = 0; i < n; i++) begin
			case (shape)
				0: xs.push_back($urandom);
				1: xs.push_back(base + $urandom_range(0, 20));
				default: xs.push_back(base + $urandom_range(0, 4000000) - 2000000);
			endcase
		end
		if (shape != 3)
			xs.sort();
		for (int i = 0; i < n; i++)
			load_pt(i, xs[i], $urandom);
	endtask

	task automatic test_short_table();
		set_count(0);
		query(32'sh8000_0000, 1'b1);
		query(32'sh7fff_ffff, 1'b0);
		load_pt(0, 32'sh0001_0000, 32'sh8000_0000);
		set_count(1);
		query(32'sh0000_0000, 1'b0);
		query(32'sh7fff_ffff, 1'b1);
	endtask

	task automatic test_edges();
		load_pt(0, 32'sh8000_0000, 32'sh7fff_ffff);
		load_pt(1, 32'shffff_0000, 32'sh8000_0000);
		load_pt(2, 32'shffff_0000, 32'sh0001_0000);
		load_pt(3, 32'sh7fff_ffff, 32'sh7fff_ffff);
		set_count(4);
		query(32'sh8000_0000, 1'b0);
		query(32'sh7fff_ffff, 1'b0);
		query(32'sh8000_0001, 1'b1);
		query(32'shffff_0000, 1'b0);
		query(32'shffff_8000, 1'b1);
		query(32'sh7fff_fffe, 1'b1);
		query(32'sh8000_0001, 1'b1);
		query(32'sh0000_0000, 1'b0);
		load_pt(63, 32'sh0, 32'sh0);
		load_pt(1, 32'sh4000_0000, 32'sh1234_5678);
		query(32'sh0000_0001, 1'b1);
	endtask

	task automatic test_count_limits();
		fill_table(TABLE_DEPTH_DEF, 0);
		set_count(127);
		query(bp_x[62] + 1, 1'b0);
		query(bp_x[1] + 1, 1'b1);
		query(bp_x[40], 1'b1);
		set_count(64);
		query(bp_x[63], 1'b0);
		query(bp_x[31] + 1, 1'b0);
		set_count(2);
		query(bp_x[0] + 1, 1'b1);
	endtask

	task automatic test_random(int unsigned target);
		int unsigned n;
		int unsigned used;
		int unsigned nq;
		int unsigned pick;
		longint lo;
		longint span;
		bit paused;
		paused = 0;
		while (beats_sent < target) begin
			case ($urandom_range(19))
				0: n = 0;
				1: n = 1;
				2: n = 64;
				3: n = $urandom_range(65, 127);
				4, 5: n = $urandom_range(9, 63);
				default: n = $urandom_range(2, 8);
			endcase
			used = (n > 64) ? 64 : n;
			set_count(0);
			pick = $urandom_range(9);
			fill_table(used, (pick < 6) ? 0 : (pick < 8) ? 2 : (pick == 8) ? 1 : 3);
			set_count(n);
			lo = (used > 0) ? longint'(bp_x[0]) : 0;
			span = (used > 0) ? longint'(bp_x[used - 1]) - lo + 3 : 1;
			if (span < 1)
				span = 1;
			nq = $urandom_range(10, 40);
			for (int i = 0; i < nq; i++) begin
				pick = $urandom_range(19);
				if (pick == 0) begin
					load_pt($urandom_range(63), $urandom, $urandom);
				end else if (pick == 1 && used > 0) begin
					query(bp_x[$urandom_range(used - 1)], 1'($urandom_range(1)));
				end else if (pick == 2) begin
					query($urandom, 1'($urandom_range(1)));
				end else begin
					query(DW'(lo - 1 + longint'({$urandom, $urandom} % span)),
						$urandom_range(3) != 0);
				end
				if (!paused && beats_sent > target / 2) begin
					paused = 1;
					drain();
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_LOAD;
		req_if.point_index = '0;
		req_if.point_x = '0;
		req_if.point_y = '0;
		req_if.query_x = '0;
		req_if.use_hint = 1'b0;
		rsp_if.ready = 1'b0;
		seg_memo = 0;
		seg_memo_ok = 0;
		pts_in_use = 0;
		err_cnt = 0;
		beats_sent = 0;
		gap_pct = 25;
		stall_pct = 65;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_table();
		test_edges();
		test_count_limits();
		test_random(800);
		gap_pct = 65;
		stall_pct = 25;
		test_random(1500);
		gap_pct = 0;
		stall_pct = 0;
		test_random(2100);
		drain();
		repeat (60) @(posedge clk);
		if (err_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
`default_nettype wire

@@ piecewise_linear_interpolator_top.f @@
hw/rtl/pli_pkg.sv
hw/rtl/pli_in_if.sv
hw/rtl/pli_out_if.sv
hw/rtl/pli_ram.sv
hw/rtl/pli_ctrl.sv
hw/rtl/pli_dp.sv
hw/rtl/piecewise_linear_interpolator_top.sv
tb/sv/piecewise_linear_interpolator_top_tb.sv
